FILE: rtl/mca_pkg.sv
// Package for the motion correlation accumulator.
// Shared constants and the front-to-back request type. No dependencies.
`default_nettype none
package mca_pkg;
    localparam int unsigned MaxFrames  = 65536;
    localparam int unsigned CountW     = 17;
    localparam int unsigned SumW       = 48;
    localparam int unsigned DW         = 32;
    localparam logic [1:0]  CfgCutoff  = 2'd0;
    localparam logic [1:0]  CfgSpacing = 2'd1;

    // one classified frame handed from the front to the back
    typedef struct packed {
        logic signed [DW-1:0] cosine;
        logic [15:0]          gap;
        logic                 last;
    } t_req;
endpackage
`default_nettype wire

FILE: rtl/motion_correlation_accumulator.sv
// Top level of the motion correlation accumulator.
// Uses mca_pkg, mca_front, mca_fifo and mca_back.
//
// Channel | Handshake          | Payload
// in      | i_valid / o_ready  | first/second d{x,y,z}, index_gap, last_frame
// out     | o_valid / i_ready  | correlation, frames_used
// cfg     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// In the front, a frame runs two 33-step square roots and six 64-step
// divides on one shared unit each; the divides are skipped when either
// vector has zero length.
// A last frame adds the mean divide in the back.
// Reset is synchronous, active low; it clears sums, counts, configuration and control state.
// The queue lets the front work on the next frame while a result waits.
`default_nettype none
module motion_correlation_accumulator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_first_dx,
    input  wire logic signed [31:0] i_first_dy,
    input  wire logic signed [31:0] i_first_dz,
    input  wire logic signed [31:0] i_second_dx,
    input  wire logic signed [31:0] i_second_dy,
    input  wire logic signed [31:0] i_second_dz,
    input  wire logic [15:0]        i_index_gap,
    input  wire logic               i_last_frame,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_correlation,
    output logic [16:0]             o_frames_used,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [30:0]        i_cfg_data
);
    import mca_pkg::*;
    logic [30:0] r_cutoff;
    logic [15:0] r_min_spacing;
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic  f_v, f_r, q_v, q_r;
    t_req  f_d, q_d;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= '0; r_min_spacing <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgCutoff:  r_cutoff <= i_cfg_data;
                CfgSpacing: r_min_spacing <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_a = '{i_first_dx, i_first_dy, i_first_dz};
    assign w_b = '{i_second_dx, i_second_dy, i_second_dz};

    mca_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_a(w_a), .i_b(w_b),
        .i_gap(i_index_gap), .i_last(i_last_frame),
        .o_req_valid(f_v), .i_req_ready(f_r), .o_req(f_d)
    );
    mca_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_data(f_d),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_d)
    );
    mca_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_req(q_d),
        .i_cutoff(r_cutoff), .i_min_spacing(r_min_spacing),
        .o_valid, .i_ready, .o_correlation, .o_frames_used
    );
endmodule
`default_nettype wire

FILE: rtl/mca_div.sv
// Sequential unsigned divider, one quotient bit per cycle (restoring).
// Uses mca_pkg.
`default_nettype none
module mca_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_quo
);
    import mca_pkg::*;
    logic [63:0]  r_rem, r_quo, r_den;
    logic [6:0]   r_cnt;
    logic         r_busy, r_done;
    logic [64:0]  n_trial;
    logic [63:0]  n_shift;

    // one restoring step
    always_comb begin
        n_shift = {r_rem[62:0], r_quo[63]};
        n_trial = {1'b0, n_shift} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                if (!n_trial[64]) begin
                    r_rem <= n_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

FILE: rtl/mca_sqrt.sv
// Sequential integer square root, one result bit per cycle.
// Uses mca_pkg.
`default_nettype none
module mca_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [65:0] i_val,
    output logic             o_done,
    output logic [32:0]      o_root
);
    import mca_pkg::*;
    logic [65:0] r_x;
    logic [32:0] r_root;
    logic [67:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [67:0] n_rem, n_trial;

    // digit-by-digit: bring down two bits, try 4r+1
    always_comb begin
        n_rem   = {r_rem[65:0], r_x[65:64]};
        n_trial = n_rem - {33'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_x    <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_x <= {r_x[63:0], 2'b00};
                if (!n_trial[67]) begin
                    r_rem  <= n_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[31:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

FILE: rtl/mca_front.sv
// Front end: accepts a frame, normalizes both vectors and forms the cosine.
// Uses mca_pkg, mca_sqrt and mca_div.
`default_nettype none
module mca_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [31:0]    i_a [3],
    input  wire logic signed [31:0]    i_b [3],
    input  wire logic [15:0]           i_gap,
    input  wire logic                  i_last,
    output logic                       o_req_valid,
    input  wire logic                  i_req_ready,
    output mca_pkg::t_req              o_req
);
    import mca_pkg::*;
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_SQRT_W, S_DIV, S_DIV_W, S_MUL, S_DOT, S_OUT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_d [6];
    logic [15:0]        r_gap;
    logic               r_last;
    logic [2:0]         r_idx;      // component index 0..5
    logic               r_vec;      // vector under sqrt
    logic [65:0]        r_sq;
    logic [32:0]        r_norm [2];
    logic signed [31:0] r_u [6];
    logic signed [63:0] r_prod;
    logic signed [65:0] r_dot;
    logic signed [31:0] r_cos;
    logic               r_zero;
    logic               r_out_v;

    logic [31:0]        n_mag;
    logic [63:0]        n_msq;
    logic               sq_start, sq_done, dv_start, dv_busy, dv_done;
    logic [32:0]        sq_root;
    logic [63:0]        dv_quo;
    logic [65:0]        n_dmag;
    logic signed [65:0] n_c;

    always_comb begin
        n_mag = r_d[r_idx][31] ? 32'(-r_d[r_idx]) : 32'(r_d[r_idx]);
        n_msq = 64'(n_mag) * 64'(n_mag);
        n_dmag = r_dot[65] ? -r_dot : r_dot;
        n_c = r_dot[65] ? -66'(n_dmag >> 30) : 66'(n_dmag >> 30);
    end

    assign sq_start = (r_state == S_SQRT);
    assign dv_start = (r_state == S_DIV);

    mca_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_start(sq_start), .i_val(r_sq),
        .o_done(sq_done), .o_root(sq_root)
    );
    mca_div u_div (
        .i_clk, .i_rst_n, .i_start(dv_start),
        .i_num({2'b00, n_mag, 30'd0}),
        .i_den({31'd0, r_norm[r_idx > 3'd2]}),
        .o_busy(dv_busy), .o_done(dv_done), .o_quo(dv_quo)
    );

    // sequencer: squares, sqrt, six divides, three products, clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    for (int k = 0; k < 3; k++) begin
                        r_d[k]   <= i_a[k];
                        r_d[k+3] <= i_b[k];
                    end
                    r_gap   <= i_gap;
                    r_last  <= i_last;
                    r_idx   <= '0;
                    r_vec   <= 1'b0;
                    r_sq    <= '0;
                    r_dot   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq <= r_sq + 66'(n_msq);
                    if (r_idx == 3'd2 || r_idx == 3'd5) r_state <= S_SQRT;
                    else r_idx <= r_idx + 3'd1;
                end
                S_SQRT: r_state <= S_SQRT_W;
                S_SQRT_W: if (sq_done) begin
                    r_norm[r_vec] <= sq_root;
                    r_sq <= '0;
                    if (!r_vec) begin
                        r_vec <= 1'b1;
                        r_idx <= 3'd3;
                        r_state <= S_SQ;
                    end else begin
                        r_zero <= (r_norm[0] == '0) || (sq_root == '0);
                        r_idx  <= '0;
                        if ((r_norm[0] == '0) || (sq_root == '0)) r_state <= S_DOT;
                        else r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_DIV_W;
                S_DIV_W: if (dv_done && !dv_busy) begin
                    r_u[r_idx] <= r_d[r_idx][31] ? -32'(dv_quo) : 32'(dv_quo);
                    if (r_idx == 3'd5) begin
                        r_idx <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                        r_state <= S_DIV;
                    end
                end
                S_MUL: begin
                    r_prod  <= 64'(r_u[r_idx]) * 64'(r_u[r_idx + 3'd3]);
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    if (r_zero) begin
                        r_cos <= '0;
                        r_out_v <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_dot <= r_dot + 66'(r_prod);
                        if (r_idx == 3'd3) begin
                            if (n_c > 66'sd1073741824) r_cos <= 32'sd1073741824;
                            else if (n_c < -66'sd1073741824) r_cos <= -32'sd1073741824;
                            else r_cos <= 32'(n_c);
                            r_out_v <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                            r_state <= (r_idx == 3'd2) ? S_DOT : S_MUL;
                        end
                    end
                end
                S_OUT: if (i_req_ready) begin
                    r_out_v <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_req_valid = r_out_v;
    assign o_req       = '{cosine: r_cos, gap: r_gap, last: r_last};

`ifndef SYNTH
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_state == S_OUT) else $error("front valid outside output");
    a_cos_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_cos <= 32'sd1073741824 && r_cos >= -32'sd1073741824))
        else $error("cosine out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_req_ready |=> $stable(r_cos)) else $error("cosine moved");
`endif
endmodule
`default_nettype wire

FILE: rtl/mca_fifo.sv
// Two-entry queue between front and back.
// Uses mca_pkg.
`default_nettype none
module mca_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mca_pkg::t_req i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mca_pkg::t_req      o_data
);
    import mca_pkg::*;
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_en, r_en;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_en = i_valid && o_ready;
    assign r_en = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_en) begin
                r_mem[r_wp] <= i_data;
                r_wp <= ~r_wp;
            end
            if (r_en) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_en} - {1'b0, r_en};
        end
    end

`ifndef SYNTH
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("ptr mismatch");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && !r_en |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count slip");
`endif
endmodule
`default_nettype wire

FILE: rtl/mca_back.sv
// Back end: accumulates cosines, forms the mean on the last frame.
// Uses mca_pkg and mca_div.
`default_nettype none
module mca_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mca_pkg::t_req i_req,
    input  wire logic [30:0]   i_cutoff,
    input  wire logic [15:0]   i_min_spacing,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic signed [31:0] o_correlation,
    output logic [16:0]        o_frames_used
);
    import mca_pkg::*;
    typedef enum logic [1:0] {S_ACC, S_DIV, S_DIV_W, S_OUT} t_state;
    localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

    t_state                r_state;
    logic signed [SumW-1:0] r_sum;
    logic [CountW-1:0]     r_cnt;
    logic signed [SumW-1:0] r_fsum;
    logic [CountW-1:0]     r_fcnt;
    logic                  r_out_v;
    logic signed [31:0]    r_corr;
    logic [16:0]           r_fu;

    logic signed [SumW:0]  n_s;
    logic signed [SumW-1:0] n_sat;
    logic                  take, dv_start, dv_busy, dv_done;
    logic [63:0]           dv_quo;
    logic [SumW-1:0]       n_mag;
    logic                  n_use;

    always_comb begin
        n_s = {r_sum[SumW-1], r_sum} + (SumW+1)'(i_req.cosine);
        if (n_s > (SumW+1)'(SumMax)) n_sat = SumMax;
        else if (n_s < (SumW+1)'(SumMin)) n_sat = SumMin;
        else n_sat = n_s[SumW-1:0];
        n_mag = r_fsum[SumW-1] ? -r_fsum : r_fsum;
    end

    assign n_use = r_cnt < CountW'(MaxFrames);
    assign o_ready = (r_state == S_ACC);
    assign take = i_valid && o_ready;
    assign dv_start = (r_state == S_DIV);

    mca_div u_div (
        .i_clk, .i_rst_n, .i_start(dv_start),
        .i_num(64'(n_mag)), .i_den(64'(r_fcnt)),
        .o_busy(dv_busy), .o_done(dv_done), .o_quo(dv_quo)
    );

    logic signed [SumW-1:0] n_mean;
    logic [SumW-1:0]        n_abs;
    always_comb begin
        n_mean = r_fsum[SumW-1] ? -SumW'(dv_quo) : SumW'(dv_quo);
        n_abs  = dv_quo[SumW-1:0];
    end

    logic r_skip;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            case (r_state)
                S_ACC: if (take) begin
                    r_fsum <= n_use ? n_sat : r_sum;
                    r_fcnt <= n_use ? r_cnt + 1'b1 : r_cnt;
                    r_skip <= !(i_req.gap > i_min_spacing);
                    if (i_req.last) begin
                        r_sum <= '0; r_cnt <= '0;
                        r_state <= S_DIV;
                    end else if (n_use) begin
                        r_sum <= n_sat; r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: r_state <= S_DIV_W;
                S_DIV_W: if (dv_done && !dv_busy) begin
                    if (r_skip || n_abs <= SumW'(i_cutoff)) r_corr <= '0;
                    else r_corr <= 32'(n_mean);
                    r_fu <= r_fcnt;
                    r_out_v <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    r_out_v <= 1'b0;
                    r_state <= S_ACC;
                end
                default: r_state <= S_ACC;
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_correlation = r_corr;
    assign o_frames_used = r_fu;

`ifndef SYNTH
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CountW'(MaxFrames)) else $error("frame count overrun");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_req.last |=> r_sum == '0 && r_cnt == '0) else $error("no clear");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_fu != '0) else $error("zero frames reported");
`endif
endmodule
`default_nettype wire
